[rtl/core/psfi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psfi_pkg;

    localparam int OFFSET_BITS_DEF      = 32;
    localparam int FRAME_COUNT_BITS_DEF = 16;

    localparam int COUNT_BITS  = 33;
    localparam int LENGTH_BITS = 32;
    localparam int FIELD_OFFSET_BITS = 32;
    localparam int FIELD_NUMBER_BITS = 16;

    // crc bytes that follow every chunk's data
    localparam logic [COUNT_BITS-1:0] CRC_BYTES = 33'd4;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_SKIP = 3'd3,
        PH_DEAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_BAD_SIG   = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_CLEAN_END = 2'd3
    } status_t;

    typedef struct packed {
        logic       stream_end;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic                         final_res;
        status_t                      status;
        logic [FIELD_NUMBER_BITS-1:0] frame_number;
        logic [FIELD_OFFSET_BITS-1:0] frame_size;
        logic [FIELD_OFFSET_BITS-1:0] frame_offset;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    // chunk type "IEND"
    function automatic logic [7:0] iend_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h45;
            2'd2:    b = 8'h4E;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/png_stream_frame_indexer.sv]
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                              tuser    tlast
// s_axis    in         data_byte[7:0]                                  -        stream_end
// m_axis    out        frame_offset[31:0] frame_size[63:32]            status   final_res
//                      frame_number[79:64]
//
// one byte per cycle while no result is held; a byte is captured in the input register and
// its result, if any, is loaded into the output register when the walker consumes the byte.
// the phase/counter update is the only loop.
// aresetn is synchronous, active low, and returns the walker to the signature phase.
// a held result stalls the walker, which then fills the input register and drops s_axis_tready.
`default_nettype none

module png_stream_frame_indexer
    import psfi_pkg::*;
#(
    parameter int OFFSET_BITS      = OFFSET_BITS_DEF,
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // frame_offset, frame_size, frame_number
    output logic [1:0]       m_axis_tuser,   // status
    output logic             m_axis_tlast
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    room;
    logic    fire;
    logic    has_result;
    result_t result;
    result_t m_result;

    assign s_item.data_byte  = s_axis_tdata;
    assign s_item.stream_end = s_axis_tlast;
    assign fire              = item_valid && room;

    psfi_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    psfi_walker #(
        .OFFSET_BITS      (OFFSET_BITS),
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    psfi_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (fire),
        .load_valid  (has_result),
        .load_result (result),
        .room        (room),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_result    (m_result)
    );

    assign m_axis_tdata = {m_result.frame_number, m_result.frame_size, m_result.frame_offset};
    assign m_axis_tuser = m_result.status;
    assign m_axis_tlast = m_result.final_res;

endmodule

`default_nettype wire

[rtl/core/psfi_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module psfi_in_reg
    import psfi_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // slot frees up in the same cycle the walker consumes it
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/core/psfi_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

module psfi_walker
    import psfi_pkg::*;
#(
    parameter int OFFSET_BITS      = OFFSET_BITS_DEF,
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t item,
    output logic       has_result,
    output result_t    result
);

    phase_t                      phase_reg, phase_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;
    logic [LENGTH_BITS-1:0]      length_reg, length_next;
    logic                        match_reg, match_next;
    logic [OFFSET_BITS-1:0]      start_reg, start_next;
    logic [OFFSET_BITS-1:0]      offset_reg, offset_next;
    logic [FRAME_COUNT_BITS-1:0] frames_reg, frames_next;

    logic                   sig_ok;
    logic                   type_ok;
    logic [COUNT_BITS-1:0]  count_dec;
    logic                   skip_done;
    logic                   completed;
    logic                   bad_sig;
    logic                   was_dead;
    logic [OFFSET_BITS-1:0] offset_inc;
    logic [OFFSET_BITS-1:0] size_raw;

    logic [OFFSET_BITS+FIELD_OFFSET_BITS-1:0]      start_ext;
    logic [OFFSET_BITS+FIELD_OFFSET_BITS-1:0]      size_ext;
    logic [FRAME_COUNT_BITS+FIELD_NUMBER_BITS-1:0] frames_ext;

    assign sig_ok     = item.data_byte == sig_byte(count_reg[2:0]);
    assign type_ok    = item.data_byte == iend_byte(count_reg[1:0]);
    assign count_dec  = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
    assign skip_done  = count_dec == '0;
    assign offset_inc = offset_reg + 1'b1;
    assign size_raw   = offset_reg - start_reg + 1'b1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SIG: begin
                if (!sig_ok) begin
                    phase_next = PH_DEAD;
                end else if (count_reg[2:0] == 3'd7) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (count_reg[1:0] == 2'd3) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (count_reg[1:0] == 2'd3) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (skip_done) begin
                    phase_next = match_reg ? PH_SIG : PH_LEN;
                end
            end
            default: phase_next = PH_DEAD;
        endcase
        if (item.stream_end) begin
            phase_next = PH_SIG;
        end
    end

    // counters, chunk fields and result flags
    always_comb begin
        count_next  = count_reg + 1'b1;
        length_next = length_reg;
        match_next  = match_reg;
        completed   = 1'b0;
        bad_sig     = 1'b0;
        was_dead    = 1'b0;
        case (phase_reg)
            PH_SIG: begin
                if (!sig_ok) begin
                    bad_sig    = 1'b1;
                    count_next = count_reg;
                end else if (count_reg[2:0] == 3'd7) begin
                    count_next  = '0;
                    length_next = '0;
                end
            end
            PH_LEN: begin
                length_next = {length_reg[LENGTH_BITS-9:0], item.data_byte};
                if (count_reg[1:0] == 2'd3) begin
                    count_next = '0;
                    match_next = 1'b1;
                end
            end
            PH_TYPE: begin
                match_next = match_reg && type_ok;
                if (count_reg[1:0] == 2'd3) begin
                    count_next = {1'b0, length_reg} + CRC_BYTES;
                end
            end
            PH_SKIP: begin
                count_next = count_dec;
                if (skip_done) begin
                    if (match_reg) begin
                        completed = 1'b1;
                    end else begin
                        length_next = '0;
                    end
                end
            end
            default: begin
                was_dead   = 1'b1;
                count_next = count_reg;
            end
        endcase

        start_next  = start_reg;
        frames_next = frames_reg;
        offset_next = offset_inc;
        if (completed) begin
            frames_next = frames_reg + 1'b1;
            start_next  = offset_inc;
            count_next  = '0;
        end
        if (item.stream_end) begin
            count_next  = '0;
            length_next = '0;
            match_next  = 1'b1;
            start_next  = '0;
            offset_next = '0;
            frames_next = '0;
        end
    end

    // result fields
    assign start_ext  = {{FIELD_OFFSET_BITS{1'b0}}, start_reg};
    assign size_ext   = {{FIELD_OFFSET_BITS{1'b0}}, size_raw};
    assign frames_ext = {{FIELD_NUMBER_BITS{1'b0}}, frames_reg};

    always_comb begin
        result.frame_offset = start_ext[FIELD_OFFSET_BITS-1:0];
        result.frame_size   = size_ext[FIELD_OFFSET_BITS-1:0];
        result.frame_number = frames_ext[FIELD_NUMBER_BITS-1:0];
        result.final_res    = item.stream_end;
        has_result          = 1'b0;
        result.status       = ST_TRUNCATED;
        if (completed) begin
            has_result    = 1'b1;
            result.status = item.stream_end ? ST_CLEAN_END : ST_COMPLETE;
        end else if (bad_sig) begin
            has_result    = 1'b1;
            result.status = ST_BAD_SIG;
        end else if (item.stream_end && !was_dead) begin
            has_result    = 1'b1;
            result.status = ST_TRUNCATED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIG;
            count_reg  <= '0;
            length_reg <= '0;
            match_reg  <= 1'b1;
            start_reg  <= '0;
            offset_reg <= '0;
            frames_reg <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            match_reg  <= match_next;
            start_reg  <= start_next;
            offset_reg <= offset_next;
            frames_reg <= frames_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/psfi_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module psfi_out_reg
    import psfi_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire logic    load_valid,
    input  wire result_t load_result,
    output logic         room,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    // room only when the held transaction is gone or leaves this cycle
    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        if (load) begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            result_reg <= load_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

[rtl/core/psfi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module psfi_checker
    import psfi_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a frame closed mid-stream never ends the stream
    a_complete_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_COMPLETE) |-> !m_axis_tlast)
        else $error("mid-stream frame marked final");

    // truncation and clean end always close the stream
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_TRUNCATED || m_axis_tuser == ST_CLEAN_END)
            |-> m_axis_tlast)
        else $error("stream end status without final mark");

endmodule

bind png_stream_frame_indexer psfi_checker u_psfi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
